// File: src/gil_pkg.sv
// gil_pkg: shared types and constants of the glyph index lookup.
// No dependencies; imported by the lookup block and its port checker.
`default_nettype none

package gil_pkg;

  localparam int GIL_MAX_RANGES = 32;
  localparam int GIL_MAX_DIRECT = 256;

  localparam int CODE_W  = 16;
  localparam int GLYPH_W = 17;
  localparam int CFG_W   = 16;

  localparam logic [CODE_W-1:0] REPL_RESET = 16'hFFFD;
  localparam logic [20:0]       BMP_LAST   = 21'h00FFFF;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_RANGE  = 2'd1;
  localparam logic [1:0] CMD_DIRECT = 2'd2;

  localparam logic [2:0] CFG_RANGES_IN_USE  = 3'd0;
  localparam logic [2:0] CFG_DIRECTS_IN_USE = 3'd1;
  localparam logic [2:0] CFG_GLYPH_TOTAL    = 3'd2;
  localparam logic [2:0] CFG_FALLBACK       = 3'd3;
  localparam logic [2:0] CFG_REPLACEMENT    = 3'd4;
  localparam logic [2:0] CFG_GLYPHS_PRESENT = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RSCAN = 4'b0010,
    S_DADDR = 4'b0100,
    S_DCHK  = 4'b1000
  } gil_state_t;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
    logic [CODE_W-1:0] base;
  } gil_range_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] glyph;
  } gil_direct_t;

endpackage

`default_nettype wire

// File: src/glyph_index_lookup.sv
// glyph_index_lookup: codepoint to glyph index with range table and sorted direct table.
// Depends on gil_pkg. Range and direct tables are internal memories.
//
// Usage: an item is taken when start is high and busy is low. Write commands
// (range entry, direct entry, or the unused code) keep busy low; their result
// strobes on out_valid the next cycle with out_found low. A lookup holds busy
// for one or two search passes: each pass reads the range entries in order
// through the single range memory port, then binary-searches the direct table
// on the single direct memory port, each step through S_DADDR and S_DCHK; nr
// range entries and nd direct entries take part (nr, nd the clamped counts).
// The result strobes on out_valid for exactly one cycle as busy drops; it is
// not held, so the receiver must take it then. Configuration writes are taken
// any cycle but only meaningful while idle.
`default_nettype none

module glyph_index_lookup
  import gil_pkg::*;
#(
  parameter int MAX_RANGES = GIL_MAX_RANGES,
  parameter int MAX_DIRECT = GIL_MAX_DIRECT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_command,
  input  wire logic [7:0]          in_entry_index,
  input  wire logic [20:0]         in_codepoint,
  input  wire logic [CODE_W-1:0]   in_range_first_code,
  input  wire logic [CODE_W-1:0]   in_range_last_code,
  input  wire logic [CODE_W-1:0]   in_range_base_glyph,
  input  wire logic [CODE_W-1:0]   in_direct_code,
  input  wire logic [CODE_W-1:0]   in_direct_glyph,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [GLYPH_W-1:0]       out_glyph_index
);

  localparam int RI_W = $clog2(MAX_RANGES + 1);
  localparam int RA_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int DI_W = $clog2(MAX_DIRECT + 1);
  localparam int DA_W = (MAX_DIRECT > 1) ? $clog2(MAX_DIRECT) : 1;

  // configuration
  logic [5:0]        ranges_in_use_r;
  logic [8:0]        directs_in_use_r;
  logic [CODE_W-1:0] glyph_total_r;
  logic [CODE_W-1:0] fallback_r;
  logic [CODE_W-1:0] repl_r;
  logic              glyphs_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ranges_in_use_r  <= '0;
      directs_in_use_r <= '0;
      glyph_total_r    <= '0;
      fallback_r       <= '0;
      repl_r           <= REPL_RESET;
      glyphs_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGES_IN_USE:  ranges_in_use_r  <= cfg_wdata[5:0];
        CFG_DIRECTS_IN_USE: directs_in_use_r <= cfg_wdata[8:0];
        CFG_GLYPH_TOTAL:    glyph_total_r    <= cfg_wdata;
        CFG_FALLBACK:       fallback_r       <= cfg_wdata;
        CFG_REPLACEMENT:    repl_r           <= cfg_wdata;
        CFG_GLYPHS_PRESENT: glyphs_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [RI_W-1:0] nr;
  logic [DI_W-1:0] nd;

  assign nr = (ranges_in_use_r > MAX_RANGES) ? RI_W'(MAX_RANGES) : RI_W'(ranges_in_use_r);
  assign nd = (directs_in_use_r > MAX_DIRECT) ? DI_W'(MAX_DIRECT) : DI_W'(directs_in_use_r);

  // control
  gil_state_t         state_r, state_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic               second_r, second_nxt;
  logic [RI_W-1:0]    ri_r, ri_nxt;
  logic               rv_r, rv_nxt;
  logic [DI_W-1:0]    lo_r, lo_nxt;
  logic [DI_W-1:0]    hi_r, hi_nxt;
  logic [DI_W-1:0]    mid_r, mid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [GLYPH_W-1:0] out_glyph_r, out_glyph_nxt;

  logic accept;
  assign accept = start && (state_r == S_IDLE);

  // tables
  gil_range_t  rng_mem [MAX_RANGES];
  gil_direct_t dir_mem [MAX_DIRECT];
  gil_range_t  rng_rdata_r;
  gil_direct_t dir_rdata_r;
  logic        rng_we, dir_we;
  logic [RA_W-1:0] rng_waddr, rng_raddr;
  logic [DA_W-1:0] dir_waddr, dir_raddr;
  logic [DI_W-1:0] mid_c;

  assign rng_we    = accept && (in_command == CMD_RANGE) && (in_entry_index < MAX_RANGES);
  assign dir_we    = accept && (in_command == CMD_DIRECT) && (in_entry_index < MAX_DIRECT);
  assign rng_waddr = RA_W'(in_entry_index);
  assign dir_waddr = DA_W'(in_entry_index);
  assign rng_raddr = ri_r[RA_W-1:0];
  assign mid_c     = lo_r + ((hi_r - lo_r) >> 1);
  assign dir_raddr = mid_c[DA_W-1:0];

  always_ff @(posedge clk) begin
    if (rng_we) begin
      rng_mem[rng_waddr] <= '{first: in_range_first_code, last: in_range_last_code,
                             base: in_range_base_glyph};
    end
    rng_rdata_r <= rng_mem[rng_raddr];
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= '{code: in_direct_code, glyph: in_direct_glyph};
    end
    dir_rdata_r <= dir_mem[dir_raddr];
  end

  // compare unit
  logic               r_hit;
  logic [GLYPH_W-1:0] r_glyph;
  logic               d_lt, d_gt, d_ok;
  logic               fb_ok;
  logic [CODE_W-1:0]  code_in;

  assign r_hit   = rv_r && (code_r >= rng_rdata_r.first) && (code_r <= rng_rdata_r.last);
  assign r_glyph = {1'b0, rng_rdata_r.base} + {1'b0, code_r - rng_rdata_r.first};
  assign d_lt    = code_r < dir_rdata_r.code;
  assign d_gt    = code_r > dir_rdata_r.code;
  assign d_ok    = glyphs_present_r && (dir_rdata_r.glyph < glyph_total_r);
  assign fb_ok   = fallback_r < glyph_total_r;
  assign code_in = (in_codepoint > BMP_LAST) ? repl_r : in_codepoint[CODE_W-1:0];

  always_comb begin
    logic pass_miss;
    pass_miss     = 1'b0;
    state_nxt     = state_r;
    code_nxt      = code_r;
    second_nxt    = second_r;
    ri_nxt        = ri_r;
    rv_nxt        = rv_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_glyph_nxt = out_glyph_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOOKUP) begin
            state_nxt  = S_RSCAN;
            code_nxt   = code_in;
            second_nxt = 1'b0;
            ri_nxt     = '0;
            rv_nxt     = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_glyph_nxt = '0;
          end
        end
      end
      S_RSCAN: begin
        if (r_hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_glyph_nxt = r_glyph;
        end else if (ri_r < nr) begin
          ri_nxt = ri_r + RI_W'(1);
          rv_nxt = 1'b1;
        end else if (rv_r) begin
          rv_nxt = 1'b0;
        end else begin
          state_nxt = S_DADDR;
          lo_nxt    = '0;
          hi_nxt    = nd;
        end
      end
      S_DADDR: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_DCHK;
        end else begin
          pass_miss = 1'b1;
        end
      end
      S_DCHK: begin
        if (d_lt) begin
          hi_nxt    = mid_r;
          state_nxt = S_DADDR;
        end else if (d_gt) begin
          lo_nxt    = mid_r + DI_W'(1);
          state_nxt = S_DADDR;
        end else if (d_ok) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_glyph_nxt = {1'b0, dir_rdata_r.glyph};
        end else begin
          pass_miss = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (pass_miss) begin
      if (!second_r && (code_r != repl_r)) begin
        state_nxt  = S_RSCAN;
        code_nxt   = repl_r;
        second_nxt = 1'b1;
        ri_nxt     = '0;
        rv_nxt     = 1'b0;
      end else begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_found_nxt = fb_ok;
        out_glyph_nxt = fb_ok ? {1'b0, fallback_r} : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      ri_r        <= '0;
      rv_r        <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      ri_r        <= ri_nxt;
      rv_r        <= rv_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    mid_r       <= mid_nxt;
    out_glyph_r <= out_glyph_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_glyph_index = out_glyph_r;

endmodule

`default_nettype wire

// File: src/gil_checker.sv
// gil_checker: port-level checks of the glyph index lookup handshake and sequencing.
// Depends on gil_pkg; bound to glyph_index_lookup below.
`default_nettype none

module gil_checker
  import gil_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_command,
  input wire logic       out_valid,
  input wire logic       out_found
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command != CMD_LOOKUP)) |=> (out_valid && !out_found && !busy))
    else $error("write item did not give a one-cycle empty result");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_LOOKUP)) |=> (busy && !out_valid))
    else $error("lookup item did not start a search");

  a_result_on_done: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("search ended without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind glyph_index_lookup gil_checker u_gil_checker (.*);

`default_nettype wire

// File: tb/glyph_index_lookup_tb.sv
// glyph_index_lookup_tb: self-checking testbench for the codepoint to glyph lookup.
// Needs gil_pkg and glyph_index_lookup; loads range and direct tables, then mixes
// directed and random lookups and checks every result against an internal predictor.
module glyph_index_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gil_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int ITEMS_TARGET = 1350;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    bit                 found;
    bit [GLYPH_W-1:0]   glyph;
  } glyph_result_t;

  class glyph_lookup_scoreboard;
    bit [5:0]          ranges_in_use;
    bit [8:0]          directs_in_use;
    bit [CODE_W-1:0]   glyph_total;
    bit [CODE_W-1:0]   last_resort_idx;
    bit [CODE_W-1:0]   replacement;
    bit                glyphs_present;
    bit [CODE_W-1:0]   range_first[GIL_MAX_RANGES];
    bit [CODE_W-1:0]   range_last[GIL_MAX_RANGES];
    bit [CODE_W-1:0]   range_base[GIL_MAX_RANGES];
    bit [CODE_W-1:0]   direct_code[GIL_MAX_DIRECT];
    bit [CODE_W-1:0]   direct_glyph[GIL_MAX_DIRECT];
    glyph_result_t     expected_glyphs[$];
    int unsigned       mismatches;

    function new();
      replacement = REPL_RESET;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_RANGES_IN_USE:  ranges_in_use = value[5:0];
        CFG_DIRECTS_IN_USE: directs_in_use = value[8:0];
        CFG_GLYPH_TOTAL:    glyph_total = value;
        CFG_FALLBACK:       last_resort_idx = value;
        CFG_REPLACEMENT:    replacement = value;
        CFG_GLYPHS_PRESENT: glyphs_present = value[0];
        default: ;
      endcase
    endfunction

    // one pass: ranges in order, then binary search over the direct table
    function bit search_pass(bit [CODE_W-1:0] code, output bit [GLYPH_W-1:0] glyph);
      int nr, nd, lo, hi, mid;
      nr = (ranges_in_use > GIL_MAX_RANGES) ? GIL_MAX_RANGES : ranges_in_use;
      nd = (directs_in_use > GIL_MAX_DIRECT) ? GIL_MAX_DIRECT : directs_in_use;
      glyph = '0;
      for (int i = 0; i < nr; i++) begin
        if (code >= range_first[i] && code <= range_last[i]) begin
          glyph = {1'b0, range_base[i]} + {1'b0, code - range_first[i]};
          return 1'b1;
        end
      end
      lo = 0;
      hi = nd;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (code < direct_code[mid]) begin
          hi = mid;
        end else if (code > direct_code[mid]) begin
          lo = mid + 1;
        end else begin
          if (glyphs_present && direct_glyph[mid] < glyph_total) begin
            glyph = {1'b0, direct_glyph[mid]};
            return 1'b1;
          end
          return 1'b0;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] slot, logic [20:0] cp,
                            logic [CODE_W-1:0] rf, rl, rb, dc, dg);
      glyph_result_t r;
      bit [CODE_W-1:0] code;
      r.found = 1'b0;
      r.glyph = '0;
      case (cmd)
        CMD_RANGE: begin
          if (slot < GIL_MAX_RANGES) begin
            range_first[slot] = rf;
            range_last[slot]  = rl;
            range_base[slot]  = rb;
          end
        end
        CMD_DIRECT: begin
          if (slot < GIL_MAX_DIRECT) begin
            direct_code[slot]  = dc;
            direct_glyph[slot] = dg;
          end
        end
        CMD_LOOKUP: begin
          code = (cp > BMP_LAST) ? replacement : cp[CODE_W-1:0];
          if (search_pass(code, r.glyph)) begin
            r.found = 1'b1;
          end else if (code != replacement && search_pass(replacement, r.glyph)) begin
            r.found = 1'b1;
          end else if (last_resort_idx < glyph_total) begin
            r.found = 1'b1;
            r.glyph = {1'b0, last_resort_idx};
          end else begin
            r.glyph = '0;
          end
        end
        default: ;
      endcase
      expected_glyphs.push_back(r);
    endfunction

    function void check_result(logic found, logic [GLYPH_W-1:0] glyph);
      glyph_result_t r;
      if (expected_glyphs.size() == 0) begin
        $error("result with none expected: found %0b glyph_index 0x%0h", found, glyph);
        mismatches++;
        return;
      end
      r = expected_glyphs.pop_front();
      if (found !== r.found) begin
        $error("found: expected %0b, actual %0b", r.found, found);
        mismatches++;
      end
      if (glyph !== r.glyph) begin
        $error("glyph_index: expected 0x%0h, actual 0x%0h", r.glyph, glyph);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_glyphs.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                start;
  logic                busy;
  logic [1:0]          in_command;
  logic [7:0]          in_entry_index;
  logic [20:0]         in_codepoint;
  logic [CODE_W-1:0]   in_range_first_code;
  logic [CODE_W-1:0]   in_range_last_code;
  logic [CODE_W-1:0]   in_range_base_glyph;
  logic [CODE_W-1:0]   in_direct_code;
  logic [CODE_W-1:0]   in_direct_glyph;
  logic                out_valid;
  logic                out_found;
  logic [GLYPH_W-1:0]  out_glyph_index;

  glyph_lookup_scoreboard sb;

  // driver-side view of the table contents, used to aim lookups
  logic [CODE_W-1:0]   plan_first[GIL_MAX_RANGES];
  logic [CODE_W-1:0]   plan_last[GIL_MAX_RANGES];
  logic [CODE_W-1:0]   plan_code[GIL_MAX_DIRECT];
  logic [CODE_W-1:0]   cur_repl;
  int                  direct_filled;
  int                  items_done;
  bit                  idling;
  int unsigned         quiet_cycles;

  glyph_index_lookup i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_entry_index      (in_entry_index),
    .in_codepoint        (in_codepoint),
    .in_range_first_code (in_range_first_code),
    .in_range_last_code  (in_range_last_code),
    .in_range_base_glyph (in_range_base_glyph),
    .in_direct_code      (in_direct_code),
    .in_direct_glyph     (in_direct_glyph),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_glyph_index     (out_glyph_index)
  );

  always #10 clk = ~clk;

  // result check, item capture and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(out_found, out_glyph_index);
      end
      if (start && !busy) begin
        sb.note_item(in_command, in_entry_index, in_codepoint, in_range_first_code,
                     in_range_last_code, in_range_base_glyph, in_direct_code,
                     in_direct_glyph);
      end
    end
    if (!rst_n || out_valid || cfg_we || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("glyph_index_lookup_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] slot,
                           input logic [20:0] cp, input logic [CODE_W-1:0] rf, rl, rb,
                           dc, dg);
    start               <= 1'b1;
    in_command          <= cmd;
    in_entry_index      <= slot;
    in_codepoint        <= cp;
    in_range_first_code <= rf;
    in_range_last_code  <= rl;
    in_range_base_glyph <= rb;
    in_direct_code      <= dc;
    in_direct_glyph     <= dg;
    do @(posedge clk); while (busy);
    if (cmd != CMD_NOP && !(cmd == CMD_RANGE && slot >= GIL_MAX_RANGES)) begin
      items_done++;
    end
    if (idling && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic put_range(input logic [7:0] slot, input logic [CODE_W-1:0] f, l, b);
    if (slot < GIL_MAX_RANGES) begin
      plan_first[slot] = f;
      plan_last[slot]  = l;
    end
    send_item(CMD_RANGE, slot, 21'($urandom), f, l, b, 16'($urandom), 16'($urandom));
  endtask

  task automatic put_direct(input logic [7:0] slot, input logic [CODE_W-1:0] c, g);
    plan_code[slot] = c;
    send_item(CMD_DIRECT, slot, 21'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), c, g);
  endtask

  task automatic look_up(input logic [20:0] cp);
    send_item(CMD_LOOKUP, 8'($urandom), cp, 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic add_noise();
    if ($urandom_range(0, 1)) begin
      send_item(CMD_NOP, 8'($urandom), 21'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_item(CMD_RANGE, 8'($urandom_range(GIL_MAX_RANGES, 255)), 21'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // waits for every pending result, then rewrites all registers;
  // unused upper bits of the narrow registers carry noise
  task automatic reconfigure(input logic [5:0] nr, input logic [8:0] nd,
                             input logic [CODE_W-1:0] gt, fb, rc, input logic gp);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    write_reg(CFG_RANGES_IN_USE, {10'($urandom), nr});
    write_reg(CFG_DIRECTS_IN_USE, {7'($urandom), nd});
    write_reg(CFG_GLYPH_TOTAL, gt);
    write_reg(CFG_FALLBACK, fb);
    write_reg(CFG_REPLACEMENT, rc);
    write_reg(CFG_GLYPHS_PRESENT, {15'($urandom), gp});
    cfg_we <= 1'b0;
    cur_repl = rc;
  endtask

  function automatic logic [CODE_W-1:0] pick_glyph(logic [CODE_W-1:0] gt);
    if ($urandom_range(0, 99) < 80) begin
      return (gt == 0) ? 16'h0000 : 16'($urandom_range(0, gt - 1));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [20:0] pick_code(int nr, int nd);
    int k, s;
    k = $urandom_range(0, 99);
    if (k < 30 && nr > 0) begin
      s = $urandom_range(0, nr - 1);
      if (plan_last[s] < plan_first[s] || k < 8) return {5'd0, plan_first[s]};
      if (k < 14) return {5'd0, plan_last[s]};
      return 21'({5'd0, plan_first[s]} + $urandom_range(0, plan_last[s] - plan_first[s]));
    end
    if (k < 60 && nd > 0) begin
      s = $urandom_range(0, nd - 1);
      return {5'd0, plan_code[s] + 16'(k < 38)};
    end
    if (k < 70) return 21'($urandom_range(32'h10000, 32'h10FFFF));
    if (k < 78) return {5'd0, cur_repl};
    return 21'($urandom_range(0, 32'hFFFF));
  endfunction

  initial begin
    int k, nr_use, nd_use, span;
    logic [5:0] nr;
    logic [8:0] nd;
    logic [CODE_W-1:0] gt, fb, repl, f, l;
    logic gp;
    bit refresh, shuffled;

    sb = new();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    start               <= 1'b0;
    in_command          <= CMD_LOOKUP;
    in_entry_index      <= '0;
    in_codepoint        <= '0;
    in_range_first_code <= '0;
    in_range_last_code  <= '0;
    in_range_base_glyph <= '0;
    in_direct_code      <= '0;
    in_direct_glyph     <= '0;
    quiet_cycles        <= 0;
    idling        = 1'b1;
    items_done    = 0;
    direct_filled = 0;
    cur_repl      = REPL_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty tables, reset registers: plain miss
    look_up(21'h000041);
    reconfigure(6'd0, 9'd0, 16'd100, 16'd7, REPL_RESET, 1'b1);
    look_up(21'h10FFFF);
    put_range(8'd0, 16'h0041, 16'h005A, 16'h0010);
    put_range(8'd1, 16'h0000, 16'h0000, 16'hFFFF);
    put_range(8'd2, 16'hFFFE, 16'hFFFF, 16'hFFFF);
    put_range(8'd32, 16'h1000, 16'h2000, 16'h0001);
    put_range(8'd255, 16'h1000, 16'h2000, 16'h0001);
    put_direct(8'd0, 16'h0100, 16'd5);
    put_direct(8'd1, 16'h0200, 16'd150);
    put_direct(8'd2, 16'hFFFD, 16'd9);
    put_direct(8'd255, 16'hFFFE, 16'hFFFF);
    send_item(CMD_NOP, 8'hFF, 21'h1FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    reconfigure(6'd3, 9'd3, 16'd100, 16'd7, 16'hFFFD, 1'b1);
    look_up(21'h000041);
    look_up(21'h00005A);
    look_up(21'h000000);
    look_up(21'h00FFFF);
    look_up(21'h000100);
    look_up(21'h000200);
    look_up(21'h10FFFF);
    look_up(21'h0FFFFF);
    look_up(21'h010000);
    look_up(21'h00FFFD);
    look_up(21'h001234);
    // direct glyphs absent and fallback not below the glyph count
    reconfigure(6'd3, 9'd3, 16'd7, 16'd7, 16'hFFFD, 1'b0);
    look_up(21'h000100);
    look_up(21'h00FFFD);

    for (int phase = 0; items_done < ITEMS_TARGET; phase++) begin
      idling = !(phase >= 4 && phase < 7);
      if (phase == 1) begin
        nr = 6'd63;
        nd = 9'd511;
      end else if (phase == 2) begin
        nr = 6'd32;
        nd = 9'd256;
      end else if ($urandom_range(0, 9) == 0) begin
        nr = 6'($urandom_range(32, 63));
        nd = 9'($urandom_range(200, 511));
      end else begin
        nr = 6'($urandom_range(0, 8));
        nd = 9'($urandom_range(0, 24));
      end
      nr_use = (nr > GIL_MAX_RANGES) ? GIL_MAX_RANGES : nr;
      nd_use = (nd > GIL_MAX_DIRECT) ? GIL_MAX_DIRECT : nd;

      k = $urandom_range(0, 99);
      gt = (k < 40) ? 16'hFFFF : (k < 70) ? 16'($urandom) :
           (k < 90) ? 16'($urandom_range(0, 64)) : 16'h0000;
      fb = ($urandom_range(0, 1) && gt != 0) ? 16'($urandom_range(0, gt - 1)) :
           16'($urandom);
      gp = ($urandom_range(0, 99) < 85);
      if (phase == 1) begin
        gt = 16'hFFFF;
        fb = 16'hFFFE;
      end else if (phase == 2) begin
        gt = 16'h0000;
        fb = 16'hFFFF;
        gp = 1'b0;
      end

      for (int i = 0; i < nr_use; i++) begin
        f = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 80) begin
          l = (f > 16'hFFBF) ? 16'hFFFF : f + 16'($urandom_range(0, 64));
        end else if (k < 97) begin
          l = (f == 0) ? 16'h0000 : f - 16'($urandom_range(1, f));
        end else begin
          l = 16'($urandom);
        end
        plan_first[i] = f;
        plan_last[i]  = l;
      end

      refresh  = nd_use > 0 && (nd_use <= 32 || nd_use > direct_filled);
      shuffled = ($urandom_range(0, 9) == 0);
      if (refresh) begin
        span = 65536 / nd_use;
        for (int i = 0; i < nd_use; i++) begin
          plan_code[i] = shuffled ? 16'($urandom) : 16'(i * span + $urandom_range(0, span - 1));
        end
      end

      k = $urandom_range(0, 99);
      if (k < 40 && nd_use > 0) repl = plan_code[$urandom_range(0, nd_use - 1)];
      else if (k < 60) repl = REPL_RESET;
      else if (k < 70 && nr_use > 0) repl = plan_first[$urandom_range(0, nr_use - 1)];
      else repl = 16'($urandom);
      if (phase == 1) repl = 16'h0000;
      if (phase == 2) repl = 16'hFFFF;

      reconfigure(nr, nd, gt, fb, repl, gp);

      for (int i = 0; i < nr_use; i++) begin
        if ($urandom_range(0, 99) < 5) add_noise();
        put_range(8'(i), plan_first[i], plan_last[i], 16'($urandom));
      end
      if (refresh) begin
        for (int i = 0; i < nd_use; i++) begin
          if ($urandom_range(0, 99) < 5) add_noise();
          put_direct(8'(i), plan_code[i], pick_glyph(gt));
        end
        if (nd_use > direct_filled) direct_filled = nd_use;
      end

      repeat ($urandom_range(20, 60)) begin
        k = $urandom_range(0, 99);
        if (k < 5) begin
          add_noise();
        end else if (k < 8) begin
          f = 16'($urandom);
          put_range(8'($urandom_range(0, GIL_MAX_RANGES - 1)), f,
                    (f > 16'hFFBF) ? 16'hFFFF : f + 16'($urandom_range(0, 64)), 16'($urandom));
        end else if (k < 10 && direct_filled > 0) begin
          put_direct(8'($urandom_range(0, direct_filled - 1)), 16'($urandom), pick_glyph(gt));
        end
        look_up(pick_code(nr_use, nd_use));
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("glyph_index_lookup_tb: clean");
    end else begin
      $display("glyph_index_lookup_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/gil_pkg.sv
src/glyph_index_lookup.sv
src/gil_checker.sv
tb/glyph_index_lookup_tb.sv
